### hw/rtl/pixel_art_scale2x_scale3x_top_macros.svh
// ----------------------------------------------------------------------------
// pixel art scaler assertion macros
// shared property forms for the scaler checks
// ----------------------------------------------------------------------------
`ifndef PIXEL_ART_SCALE2X_SCALE3X_TOP_MACROS_SVH
`define PIXEL_ART_SCALE2X_SCALE3X_TOP_MACROS_SVH

// same-cycle implication
`define SCX_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SCX_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/scx_pkg.sv
// ----------------------------------------------------------------------------
// scx_pkg
// shared types and codes of the pixel art scaler
// ----------------------------------------------------------------------------
package scx_pkg;

    localparam int unsigned PixW   = 32;
    localparam int unsigned CoordW = 12;
    localparam int unsigned CfgW   = 11;

    typedef enum logic [0:0] {
        REQ_PIXEL = 1'b0,
        REQ_DRAIN = 1'b1
    } t_req_kind;

    typedef enum logic [0:0] {
        CFG_SCALE_MODE  = 1'b0,
        CFG_FRAME_WIDTH = 1'b1
    } t_cfg_idx;

    typedef enum logic [0:0] {
        MODE_2X = 1'b0,
        MODE_3X = 1'b1
    } t_mode;

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_RD_L,
        FS_RD_C,
        FS_RD_R,
        FS_CAP_R,
        FS_FULL
    } t_fetch_st;

    typedef struct packed {
        t_req_kind          req_type;
        logic [PixW-1:0]    src_pixel;
    } t_req;

    typedef struct packed {
        logic [PixW-1:0]    out_pixel;
        logic [CoordW-1:0]  dst_x;
        logic [CoordW-1:0]  dst_y;
        logic               block_last;
    } t_res;

    // one block request, or two adjacent ones when two is set
    typedef struct packed {
        logic [CoordW-1:0]  x;
        logic [CoordW-1:0]  y;
        logic               two;
        logic [1:0]         top;
        logic [1:0]         mid;
        logic [1:0]         bot;
    } t_job;

    typedef struct packed {
        logic               en;
        logic [1:0]         slot;
        logic [CoordW-1:0]  addr;
        logic [PixW-1:0]    data;
    } t_wr;

    typedef struct packed {
        t_mode              mode;
        logic [CoordW-1:0]  w_last;
    } t_cfg;

    typedef struct packed {
        logic               q_empty;
        logic               fetching;
    } t_hazard;

endpackage

### hw/rtl/scx_front.sv
// ----------------------------------------------------------------------------
// scx_front
// takes requests, writes row stores, queues block requests
// ----------------------------------------------------------------------------
module scx_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  scx_pkg::t_cfg_idx                 i_cfg_idx,
    input  logic [scx_pkg::CfgW-1:0]          i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  scx_pkg::t_req                     i_in_req,
    input  logic                              i_q_full,
    input  scx_pkg::t_hazard                  i_hz,
    output logic                              o_push,
    output scx_pkg::t_job                     o_job,
    output scx_pkg::t_wr                      o_wr,
    output scx_pkg::t_cfg                     o_cfg
);

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    scx_pkg::t_mode             r_mode;
    logic [scx_pkg::CfgW-1:0]   r_fw;
    logic [CW-1:0]              r_col;
    logic [HW-1:0]              r_row;
    logic [1:0]                 r_rot;
    logic [CW-1:0]              r_drain;

    logic [CW-1:0]              w;
    logic [CW-1:0]              w_last;
    logic [CW-1:0]              cc;
    logic [CW-1:0]              dp;
    logic [1:0]                 s_mid;
    logic [1:0]                 s_nxt;
    logic [1:0]                 s_top;
    logic                       is_pix;
    logic                       pix_ignore;
    logic                       pix_has;
    logic                       drain_ok;
    logic                       acc;

    always_comb begin
        if (r_fw == '0) begin
            w = CW'(1);
        end else if (32'(r_fw) > MAX_WIDTH) begin
            w = CW'(MAX_WIDTH);
        end else begin
            w = CW'(r_fw);
        end
    end

    assign w_last     = w - CW'(1);
    assign cc         = (r_col >= w) ? '0 : r_col;
    assign dp         = (r_drain >= w) ? '0 : r_drain;
    assign s_mid      = (r_rot == 2'd0) ? 2'd2 : r_rot - 2'd1;
    assign s_nxt      = (r_rot == 2'd2) ? 2'd0 : r_rot + 2'd1;
    assign s_top      = (32'(r_row) >= 2) ? s_nxt : s_mid;
    assign is_pix     = (i_in_req.req_type == scx_pkg::REQ_PIXEL);
    assign pix_ignore = (cc == '0) && (32'(r_row) >= MAX_HEIGHT);
    assign pix_has    = (r_row != '0) && ((cc != '0) || (cc == w_last));
    assign drain_ok   = (r_col == '0) && (r_row != '0);

    // a new row overwrites the oldest slot, so wait until no read is pending
    assign o_in_ready = !i_q_full &&
                        !(is_pix && (cc == '0) && (!i_hz.q_empty || i_hz.fetching));
    assign acc        = i_in_valid && o_in_ready;

    always_comb begin
        o_push     = acc && (is_pix ? (!pix_ignore && pix_has) : drain_ok);
        o_job.x    = is_pix ? scx_pkg::CoordW'((cc != '0) ? cc - CW'(1) : cc)
                            : scx_pkg::CoordW'(dp);
        o_job.y    = scx_pkg::CoordW'(r_row - HW'(1));
        o_job.two  = is_pix && (cc != '0) && (cc == w_last);
        o_job.top  = s_top;
        o_job.mid  = s_mid;
        o_job.bot  = is_pix ? r_rot : s_mid;
        o_wr.en    = acc && is_pix && !pix_ignore;
        o_wr.slot  = r_rot;
        o_wr.addr  = scx_pkg::CoordW'(cc);
        o_wr.data  = i_in_req.src_pixel;
        o_cfg.mode   = r_mode;
        o_cfg.w_last = scx_pkg::CoordW'(w_last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= scx_pkg::MODE_2X;
            r_fw    <= scx_pkg::CfgW'(1);
            r_col   <= '0;
            r_row   <= '0;
            r_rot   <= '0;
            r_drain <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                scx_pkg::CFG_SCALE_MODE: begin
                    r_mode <= scx_pkg::t_mode'(i_cfg_data[0]);
                end
                scx_pkg::CFG_FRAME_WIDTH: begin
                    r_fw <= i_cfg_data;
                end
                default: begin
                end
            endcase
            r_col   <= '0;
            r_row   <= '0;
            r_rot   <= '0;
            r_drain <= '0;
        end else if (acc) begin
            if (is_pix) begin
                if (!pix_ignore) begin
                    r_drain <= '0;
                    if (cc == w_last) begin
                        r_col <= '0;
                        r_row <= r_row + HW'(1);
                        r_rot <= s_nxt;
                    end else begin
                        r_col <= cc + CW'(1);
                    end
                end
            end else if (drain_ok) begin
                if (dp + CW'(1) >= w) begin
                    // last drain tick ends the frame
                    r_col   <= '0;
                    r_row   <= '0;
                    r_rot   <= '0;
                    r_drain <= '0;
                end else begin
                    r_drain <= dp + CW'(1);
                end
            end
        end
    end

endmodule

### hw/rtl/scx_fifo.sv
// ----------------------------------------------------------------------------
// scx_fifo
// two-entry queue of block requests between front and back
// ----------------------------------------------------------------------------
module scx_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  scx_pkg::t_job   i_job,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output scx_pkg::t_job   o_head
);

    scx_pkg::t_job  r_q [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_head  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

### hw/rtl/scx_back.sv
// ----------------------------------------------------------------------------
// scx_back
// row stores, neighbor fetch and block emission
// ----------------------------------------------------------------------------
module scx_back #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  scx_pkg::t_wr        i_wr,
    input  scx_pkg::t_cfg       i_cfg,
    input  logic                i_q_empty,
    input  scx_pkg::t_job       i_q_head,
    output logic                o_q_pop,
    output logic                o_fetching,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output scx_pkg::t_res       o_out_res
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CdW = scx_pkg::CoordW;

    logic [scx_pkg::PixW-1:0]   r_mem0 [MAX_WIDTH];
    logic [scx_pkg::PixW-1:0]   r_mem1 [MAX_WIDTH];
    logic [scx_pkg::PixW-1:0]   r_mem2 [MAX_WIDTH];
    logic [scx_pkg::PixW-1:0]   r_rd0;
    logic [scx_pkg::PixW-1:0]   r_rd1;
    logic [scx_pkg::PixW-1:0]   r_rd2;

    scx_pkg::t_fetch_st         r_st;
    scx_pkg::t_fetch_st         n_st;
    logic                       r_sub;
    logic [AW-1:0]              r_bx;
    logic [CdW-1:0]             r_by;
    logic [1:0]                 r_top;
    logic [1:0]                 r_mid;
    logic [1:0]                 r_bot;
    logic [scx_pkg::PixW-1:0]   r_nb [9];

    logic                       start;
    logic                       take;
    logic                       rd_en;
    logic [AW-1:0]              rd_addr;
    logic                       cap_en;
    logic [1:0]                 cap_col;
    logic [AW-1:0]              xl;
    logic [AW-1:0]              xr;

    // emitter
    logic [scx_pkg::PixW-1:0]   r_res [9];
    logic                       r_busy;
    logic [3:0]                 r_k;
    logic [3:0]                 r_kl;
    logic [1:0]                 r_dx;
    logic [1:0]                 r_dy;
    logic [CdW-1:0]             r_xb;
    logic [CdW-1:0]             r_yb;
    logic                       r_ov;
    scx_pkg::t_res              r_out;
    logic                       adv;
    logic                       last;
    logic [scx_pkg::PixW-1:0]   res [9];
    logic                       tl, tr, bl, br;
    logic                       mode3;
    logic [CdW-1:0]             bx_ext;

    function automatic logic [scx_pkg::PixW-1:0] sel_slot(
        input logic [1:0] slot,
        input logic [scx_pkg::PixW-1:0] d0,
        input logic [scx_pkg::PixW-1:0] d1,
        input logic [scx_pkg::PixW-1:0] d2
    );
        logic [scx_pkg::PixW-1:0] d;
        case (slot)
            2'd0:    d = d0;
            2'd1:    d = d1;
            default: d = d2;
        endcase
        return d;
    endfunction

    // row stores: one write from the front, one read per slot
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            case (i_wr.slot)
                2'd0:    r_mem0[i_wr.addr[AW-1:0]] <= i_wr.data;
                2'd1:    r_mem1[i_wr.addr[AW-1:0]] <= i_wr.data;
                default: r_mem2[i_wr.addr[AW-1:0]] <= i_wr.data;
            endcase
        end
        if (rd_en) begin
            r_rd0 <= r_mem0[rd_addr];
            r_rd1 <= r_mem1[rd_addr];
            r_rd2 <= r_mem2[rd_addr];
        end
    end

    // fetch sequencer
    assign mode3 = (i_cfg.mode == scx_pkg::MODE_3X);
    assign adv   = !r_ov || i_out_ready;
    assign last  = (r_k == r_kl);
    assign take  = (r_st == scx_pkg::FS_FULL) && (!r_busy || (adv && last));
    assign start = ((r_st == scx_pkg::FS_IDLE) || take) && !i_q_empty;
    assign o_q_pop = start && !(i_q_head.two && !r_sub);
    assign xl = (r_bx == '0) ? r_bx : r_bx - AW'(1);
    assign xr = (CdW'(r_bx) == i_cfg.w_last) ? r_bx : r_bx + AW'(1);

    always_comb begin
        case (r_st)
            scx_pkg::FS_IDLE:  n_st = start ? scx_pkg::FS_RD_L : scx_pkg::FS_IDLE;
            scx_pkg::FS_RD_L:  n_st = scx_pkg::FS_RD_C;
            scx_pkg::FS_RD_C:  n_st = scx_pkg::FS_RD_R;
            scx_pkg::FS_RD_R:  n_st = scx_pkg::FS_CAP_R;
            scx_pkg::FS_CAP_R: n_st = scx_pkg::FS_FULL;
            scx_pkg::FS_FULL: begin
                if (start) begin
                    n_st = scx_pkg::FS_RD_L;
                end else if (take) begin
                    n_st = scx_pkg::FS_IDLE;
                end else begin
                    n_st = scx_pkg::FS_FULL;
                end
            end
            default:           n_st = scx_pkg::FS_IDLE;
        endcase
    end

    always_comb begin
        rd_en      = 1'b0;
        rd_addr    = r_bx;
        cap_en     = 1'b0;
        cap_col    = 2'd0;
        o_fetching = 1'b0;
        case (r_st)
            scx_pkg::FS_RD_L: begin
                rd_en      = 1'b1;
                rd_addr    = xl;
                o_fetching = 1'b1;
            end
            scx_pkg::FS_RD_C: begin
                rd_en      = 1'b1;
                cap_en     = 1'b1;
                o_fetching = 1'b1;
            end
            scx_pkg::FS_RD_R: begin
                rd_en      = 1'b1;
                rd_addr    = xr;
                cap_en     = 1'b1;
                cap_col    = 2'd1;
                o_fetching = 1'b1;
            end
            scx_pkg::FS_CAP_R: begin
                cap_en  = 1'b1;
                cap_col = 2'd2;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= scx_pkg::FS_IDLE;
            r_sub <= 1'b0;
        end else begin
            r_st <= n_st;
            if (start) begin
                r_sub <= i_q_head.two && !r_sub;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_bx  <= i_q_head.x[AW-1:0] + AW'(r_sub);
            r_by  <= i_q_head.y;
            r_top <= i_q_head.top;
            r_mid <= i_q_head.mid;
            r_bot <= i_q_head.bot;
        end
        if (cap_en) begin
            case (cap_col)
                2'd0: begin
                    r_nb[0] <= sel_slot(r_top, r_rd0, r_rd1, r_rd2);
                    r_nb[3] <= sel_slot(r_mid, r_rd0, r_rd1, r_rd2);
                    r_nb[6] <= sel_slot(r_bot, r_rd0, r_rd1, r_rd2);
                end
                2'd1: begin
                    r_nb[1] <= sel_slot(r_top, r_rd0, r_rd1, r_rd2);
                    r_nb[4] <= sel_slot(r_mid, r_rd0, r_rd1, r_rd2);
                    r_nb[7] <= sel_slot(r_bot, r_rd0, r_rd1, r_rd2);
                end
                default: begin
                    r_nb[2] <= sel_slot(r_top, r_rd0, r_rd1, r_rd2);
                    r_nb[5] <= sel_slot(r_mid, r_rd0, r_rd1, r_rd2);
                    r_nb[8] <= sel_slot(r_bot, r_rd0, r_rd1, r_rd2);
                end
            endcase
        end
    end

    // scale rules, neighbors A..I in r_nb[0..8]
    always_comb begin
        tl = (r_nb[3] == r_nb[1]) && (r_nb[3] != r_nb[7]) && (r_nb[1] != r_nb[5]);
        tr = (r_nb[1] == r_nb[5]) && (r_nb[1] != r_nb[3]) && (r_nb[5] != r_nb[7]);
        bl = (r_nb[7] == r_nb[3]) && (r_nb[7] != r_nb[5]) && (r_nb[3] != r_nb[1]);
        br = (r_nb[5] == r_nb[7]) && (r_nb[5] != r_nb[1]) && (r_nb[7] != r_nb[3]);
        for (int i = 0; i < 9; i++) begin
            res[i] = r_nb[4];
        end
        if (r_nb[4][31:24] == 8'd0) begin
            for (int i = 0; i < 9; i++) begin
                res[i] = '0;
            end
        end else if (!mode3) begin
            if (tl) res[0] = r_nb[1];
            if (tr) res[1] = r_nb[5];
            if (bl) res[2] = r_nb[3];
            if (br) res[3] = r_nb[7];
        end else begin
            if (tl) res[0] = r_nb[3];
            if ((tl && r_nb[4] != r_nb[2]) || (tr && r_nb[4] != r_nb[0])) res[1] = r_nb[1];
            if (tr) res[2] = r_nb[5];
            if ((bl && r_nb[4] != r_nb[0]) || (tl && r_nb[4] != r_nb[6])) res[3] = r_nb[3];
            if ((tr && r_nb[4] != r_nb[8]) || (br && r_nb[4] != r_nb[2])) res[5] = r_nb[5];
            if (bl) res[6] = r_nb[3];
            if ((br && r_nb[4] != r_nb[6]) || (bl && r_nb[4] != r_nb[8])) res[7] = r_nb[7];
            if (br) res[8] = r_nb[5];
        end
    end

    assign bx_ext = CdW'(r_bx);

    always_ff @(posedge i_clk) begin
        if (take) begin
            for (int i = 0; i < 9; i++) begin
                r_res[i] <= res[i];
            end
            r_kl <= mode3 ? 4'd8 : 4'd3;
            r_xb <= mode3 ? {bx_ext[CdW-2:0], 1'b0} + bx_ext : {bx_ext[CdW-2:0], 1'b0};
            r_yb <= mode3 ? {r_by[CdW-2:0], 1'b0} + r_by : {r_by[CdW-2:0], 1'b0};
        end
        if (adv && r_busy) begin
            r_out.out_pixel  <= r_res[r_k];
            r_out.dst_x      <= r_xb + CdW'(r_dx);
            r_out.dst_y      <= r_yb + CdW'(r_dy);
            r_out.block_last <= last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
            r_k    <= '0;
            r_dx   <= '0;
            r_dy   <= '0;
        end else begin
            if (adv) begin
                r_ov <= r_busy;
            end
            if (adv && r_busy) begin
                r_k <= r_k + 4'd1;
                // wrap the column at the block edge
                if ((r_dx == 2'd2) || (!mode3 && r_dx == 2'd1)) begin
                    r_dx <= '0;
                    r_dy <= r_dy + 2'd1;
                end else begin
                    r_dx <= r_dx + 2'd1;
                end
                if (last) begin
                    r_busy <= 1'b0;
                end
            end
            if (take) begin
                r_busy <= 1'b1;
                r_k    <= '0;
                r_dx   <= '0;
                r_dy   <= '0;
            end
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_res   = r_out;

endmodule

### hw/rtl/pixel_art_scale2x_scale3x_top.sv
// ----------------------------------------------------------------------------
// pixel_art_scale2x_scale3x_top
// scale2x / scale3x pixel art enlarger over a raster pixel stream
// ----------------------------------------------------------------------------
// channel   direction  handshake                   payload
// in        input      i_in_valid / o_in_ready     i_in_req  (t_req)
// out       output     o_out_valid / i_out_ready   o_out_res (t_res)
// cfg       input      i_cfg_we                    i_cfg_idx, i_cfg_data
//
// a block is streamed at one pixel per cycle while the output is ready;
// in 2x mode the neighbor fetch (three row store reads) sets the pace.
// a pixel that starts a row waits until queued blocks have read their neighbors.
// synchronous active-low reset clears control state; row stores are not cleared.
// either side may stall; a two-entry queue sits between front and back.
`include "pixel_art_scale2x_scale3x_top_macros.svh"

module pixel_art_scale2x_scale3x_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  scx_pkg::t_cfg_idx           i_cfg_idx,
    input  logic [scx_pkg::CfgW-1:0]    i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  scx_pkg::t_req               i_in_req,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output scx_pkg::t_res               o_out_res
);

    logic               q_push;
    logic               q_pop;
    logic               q_full;
    scx_pkg::t_job      job;
    scx_pkg::t_job      head;
    scx_pkg::t_wr       wr;
    scx_pkg::t_cfg      cfg;
    scx_pkg::t_hazard   hz;
    logic               fetching;
    logic               q_empty;
    logic               row_start_wr;
    logic               last_2x;
    logic               odd_corner;

    assign hz.q_empty  = q_empty;
    assign hz.fetching = fetching;

    scx_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_req   (i_in_req),
        .i_q_full   (q_full),
        .i_hz       (hz),
        .o_push     (q_push),
        .o_job      (job),
        .o_wr       (wr),
        .o_cfg      (cfg)
    );

    scx_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (job),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head)
    );

    scx_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (wr),
        .i_cfg       (cfg),
        .i_q_empty   (q_empty),
        .i_q_head    (head),
        .o_q_pop     (q_pop),
        .o_fetching  (fetching),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_res   (o_out_res)
    );

    assign row_start_wr = wr.en && (wr.addr == '0);
    assign last_2x      = o_out_valid && o_out_res.block_last &&
                          (cfg.mode == scx_pkg::MODE_2X);
    assign odd_corner   = o_out_res.dst_x[0] && o_out_res.dst_y[0];

    `SCX_ASSERT_IMP(a_no_overflow, q_push, !q_full, "block queue overflow")
    `SCX_ASSERT_IMP(a_row_start_safe, row_start_wr, q_empty && !fetching, "row start overwrite")
    `SCX_ASSERT_IMP(a_2x_last_corner, last_2x, odd_corner, "2x block ends off its corner")
    `SCX_ASSERT_NXT(a_pop_fetch, q_pop, fetching, "popped request not fetched")

endmodule
